// ===== rtl/core/indexed_min_priority_queue_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef INDEXED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Implication checked on every clock, quiet in reset.
`define IMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define IMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/impq_pkg.sv =====
`default_nettype none
package impq_pkg;
  localparam int DEF_ENTRIES = 256;

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_POP      = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_CONTAINS = 3'd3;
  localparam logic [2:0] CMD_TRIM     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Scan kinds requested by the controller.
  localparam logic [1:0] SCAN_FIND = 2'd0;  // coordinate match and first free
  localparam logic [1:0] SCAN_MIN  = 2'd1;
  localparam logic [1:0] SCAN_MAX  = 2'd2;

  typedef struct packed {
    logic       scan_start;  // clear scan accumulators, begin sweep
    logic [1:0] scan_kind;
    logic       do_write;    // write coord/cost to write slot, set valid
    logic       do_update;   // write cost only at found slot
    logic       drop_found;  // invalidate found slot
    logic       drop_best;   // invalidate best slot of last scan
    logic       latch_pop;   // capture best slot as popped data
  } impq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic free_ok;
    logic best_ok;
    logic cost_match;
  } impq_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/indexed_min_priority_queue_top.sv =====
`default_nettype none
// Indexed minimum priority queue. A request is taken when start is high and
// busy is low; the result appears on out_* for exactly one cycle with
// out_valid high and cannot be stalled. A push, pop, remove or contains
// request sweeps the slot memory once to look up the coordinate, free slot or
// extreme cost, then once more to find the new minimum. An unknown command or
// a trim of zero runs only the minimum sweep. Trim repeats the maximum sweep
// for each removed entry, plus one more when the count exceeds the number of
// stored entries, and then runs the minimum sweep. Each sweep reads the slots
// one by one through the single read port of the slot memory.
module indexed_min_priority_queue_top #(
  parameter int ENTRIES = impq_pkg::DEF_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_coord,
  input  wire logic [31:0] in_cost,
  input  wire logic [8:0]  in_count,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_coord,
  output logic [31:0]      out_cost,
  output logic [31:0]      out_min_coord,
  output logic [31:0]      out_min_cost,
  output logic             out_is_empty,
  output logic [$clog2(ENTRIES+1)-1:0] out_length
);
  import impq_pkg::*;

  impq_cmd_t  cmd;
  impq_stat_t stat;

  impq_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_cmd, .in_count, .stat, .cmd,
    .busy, .out_valid, .out_status
  );

  impq_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .start, .busy, .in_coord, .in_cost, .cmd, .stat,
    .pop_coord(out_coord), .pop_cost(out_cost),
    .min_coord(out_min_coord), .min_cost(out_min_cost), .length(out_length)
  );

  assign out_is_empty = (out_length == '0);
endmodule
`default_nettype wire

// ===== rtl/core/impq_ctrl.sv =====
`default_nettype none
module impq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [8:0]         in_count,
  input  wire impq_pkg::impq_stat_t stat,
  output impq_pkg::impq_cmd_t     cmd,
  output logic                    busy,
  output logic                    out_valid,
  output logic [1:0]              out_status
);
  import impq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_TRIM  = 3'd3;
  localparam logic [2:0] S_MIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [8:0] left_r, left_nxt;
  logic [1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= CMD_PUSH;
      left_r  <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      left_r  <= left_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    left_nxt  = left_r;
    st_nxt    = st_r;
    cmd       = '0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_cmd;
          left_nxt = in_count;
          st_nxt   = ST_OK;
          cmd.scan_start = 1'b1;
          priority case (in_cmd)
            CMD_POP:  cmd.scan_kind = SCAN_MIN;
            CMD_TRIM: cmd.scan_kind = SCAN_MAX;
            default:  cmd.scan_kind = SCAN_FIND;
          endcase
          if (in_cmd == CMD_TRIM && in_count == 9'd0) begin
            cmd.scan_kind = SCAN_MIN;
            state_nxt = S_MIN;
          end else if (in_cmd == CMD_PUSH || in_cmd == CMD_POP ||
                       in_cmd == CMD_REMOVE || in_cmd == CMD_CONTAINS ||
                       in_cmd == CMD_TRIM) begin
            state_nxt = S_SCAN;
          end else begin
            st_nxt = ST_MISS;
            cmd.scan_kind = SCAN_MIN;
            state_nxt = S_MIN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = (op_r == CMD_TRIM) ? S_TRIM : S_ACT;
      end
      S_ACT: begin
        priority case (op_r)
          CMD_PUSH: begin
            if (stat.found) cmd.do_update = 1'b1;
            else if (stat.free_ok) cmd.do_write = 1'b1;
            else st_nxt = ST_FULL;
          end
          CMD_POP: begin
            if (stat.best_ok) begin
              cmd.latch_pop = 1'b1;
              cmd.drop_best = 1'b1;
            end else st_nxt = ST_MISS;
          end
          CMD_REMOVE: begin
            if (stat.found && stat.cost_match) cmd.drop_found = 1'b1;
            else st_nxt = ST_MISS;
          end
          default: begin
            if (!stat.found) st_nxt = ST_MISS;
          end
        endcase
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = SCAN_MIN;
        state_nxt      = S_MIN;
      end
      S_TRIM: begin
        cmd.scan_start = 1'b1;
        if (stat.best_ok) begin
          cmd.drop_best = 1'b1;
          left_nxt = left_r - 9'd1;
        end
        if (stat.best_ok && left_r != 9'd1) begin
          cmd.scan_kind = SCAN_MAX;
          state_nxt = S_SCAN;
        end else begin
          cmd.scan_kind = SCAN_MIN;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (stat.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_status = st_r;
endmodule
`default_nettype wire

// ===== rtl/core/impq_dp.sv =====
`default_nettype none
module impq_dp #(
  parameter int ENTRIES = impq_pkg::DEF_ENTRIES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [31:0]          in_coord,
  input  wire logic [31:0]          in_cost,
  input  wire impq_pkg::impq_cmd_t  cmd,
  output impq_pkg::impq_stat_t      stat,
  output logic [31:0]               pop_coord,
  output logic [31:0]               pop_cost,
  output logic [31:0]               min_coord,
  output logic [31:0]               min_cost,
  output logic [$clog2(ENTRIES+1)-1:0] length
);
  import impq_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  logic [31:0] coord_mem [ENTRIES];
  logic [31:0] cost_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [31:0] key_r, kcost_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]  kind_r;
  logic        run_r;       // sweep issuing addresses
  logic        rd_v_r;      // registered read data valid
  logic [IW-1:0] addr_r, rd_idx_r;
  logic        last_r, rd_last_r, done_r;
  logic [31:0] rd_coord_r, rd_cost_r;
  logic        rd_valid_bit_r;

  logic        found_r, free_ok_r, best_ok_r, match_r;
  logic [IW-1:0] found_idx_r, free_idx_r, best_idx_r;
  logic [31:0] best_cost_r, best_coord_r;
  logic [31:0] pop_coord_r, pop_cost_r;

  logic better;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      coord_mem[free_idx_r] <= key_r;
      cost_mem[free_idx_r]  <= kcost_r;
    end else if (cmd.do_update) begin
      cost_mem[found_idx_r] <= kcost_r;
    end
    rd_coord_r <= coord_mem[addr_r];
    rd_cost_r  <= cost_mem[addr_r];
  end

  always_comb begin
    if (kind_r == SCAN_MAX) better = !best_ok_r || (rd_cost_r > best_cost_r);
    else                    better = !best_ok_r || (rd_cost_r < best_cost_r);
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key_r   <= in_coord;
      kcost_r <= in_cost;
    end
    if (cmd.latch_pop) begin
      pop_coord_r <= best_coord_r;
      pop_cost_r  <= best_cost_r;
    end else if (start && !busy) begin
      pop_coord_r <= '0;
      pop_cost_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      cnt_r     <= '0;
      run_r     <= 1'b0;
      rd_v_r    <= 1'b0;
      done_r    <= 1'b0;
      kind_r    <= SCAN_FIND;
      addr_r    <= '0;
      last_r    <= 1'b0;
      rd_last_r <= 1'b0;
      rd_idx_r  <= '0;
      rd_valid_bit_r <= 1'b0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      best_ok_r <= 1'b0;
      match_r   <= 1'b0;
      found_idx_r <= '0;
      free_idx_r  <= '0;
      best_idx_r  <= '0;
      best_cost_r <= '0;
      best_coord_r <= '0;
    end else begin
      done_r <= !cmd.scan_start && rd_v_r && rd_last_r;
      if (cmd.do_write) begin
        valid_r[free_idx_r] <= 1'b1;
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.drop_found) begin
        valid_r[found_idx_r] <= 1'b0;
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.drop_best) begin
        valid_r[best_idx_r] <= 1'b0;
        cnt_r <= cnt_r - CW'(1);
      end
      // Read pipeline stage.
      rd_v_r         <= run_r && !cmd.scan_start;
      rd_idx_r       <= addr_r;
      rd_last_r      <= last_r;
      rd_valid_bit_r <= valid_r[addr_r];
      if (cmd.scan_start) begin
        kind_r    <= cmd.scan_kind;
        run_r     <= 1'b1;
        addr_r    <= '0;
        last_r    <= (ENTRIES == 1);
        found_r   <= 1'b0;
        free_ok_r <= 1'b0;
        best_ok_r <= 1'b0;
        match_r   <= 1'b0;
      end else begin
        if (run_r) begin
          if (last_r) run_r <= 1'b0;
          else begin
            addr_r <= addr_r + IW'(1);
            last_r <= (addr_r == IW'(ENTRIES-2));
          end
        end
        if (rd_v_r) begin
          // Valid bits of this slot cannot change mid-scan.
          if (rd_valid_bit_r) begin
            if (!found_r && rd_coord_r == key_r) begin
              found_r     <= 1'b1;
              found_idx_r <= rd_idx_r;
              match_r     <= (rd_cost_r == kcost_r);
            end
            if (better) begin
              best_ok_r    <= 1'b1;
              best_idx_r   <= rd_idx_r;
              best_cost_r  <= rd_cost_r;
              best_coord_r <= rd_coord_r;
            end
          end else if (!free_ok_r) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= rd_idx_r;
          end
        end
      end
    end
  end

  assign stat.scan_done  = done_r;
  assign stat.found      = found_r;
  assign stat.free_ok    = free_ok_r;
  assign stat.best_ok    = best_ok_r;
  assign stat.cost_match = match_r;

  assign pop_coord = pop_coord_r;
  assign pop_cost  = pop_cost_r;
  assign min_coord = best_ok_r ? best_coord_r : 32'd0;
  assign min_cost  = best_ok_r ? best_cost_r  : 32'd0;
  assign length    = cnt_r;
endmodule
`default_nettype wire

// ===== rtl/core/impq_checker.sv =====
`default_nettype none
`include "indexed_min_priority_queue_top_assert.svh"
module impq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic        out_is_empty,
  input wire logic [31:0] out_min_cost
);
  `IMPQ_ASSERT_IMPL(a_res_busy, clk, rst_n, out_valid, busy)
  `IMPQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `IMPQ_ASSERT_NEXT(a_res_end, clk, rst_n, out_valid, !busy && !out_valid)
  `IMPQ_ASSERT_IMPL(a_empty_min, clk, rst_n, out_valid && out_is_empty, out_min_cost == 32'd0)
  `IMPQ_ASSERT_IMPL(a_status, clk, rst_n, out_valid, out_status != 2'd3)
endmodule

bind indexed_min_priority_queue_top impq_checker u_impq_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status,
  .out_is_empty, .out_min_cost(out_min_cost)
);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import impq_pkg::*;

  localparam int NSLOT = DEF_ENTRIES;
  localparam int LW = $clog2(NSLOT + 1);
  localparam int NUM_ITEMS = 1500;
  localparam int POOL = 320;
  // Trim of a full table with an oversized count is the slowest request the block serves.
  localparam int DRAIN_CYCLES = (NSLOT + 2) * (NSLOT + 3) + 100;

  typedef struct {
    logic [1:0]    status;
    logic [31:0]   pop_coord;
    logic [31:0]   pop_cost;
    logic [31:0]   min_coord;
    logic [31:0]   min_cost;
    logic          empty;
    logic [LW-1:0] len;
  } queue_result_t;

  class mpq_scoreboard;
    bit          slot_used[NSLOT];
    logic [31:0] slot_key[NSLOT];
    logic [31:0] slot_val[NSLOT];
    int          used_count;
    queue_result_t expected_q[$];
    int errors;
    int results_seen;
    int pops;
    int fulls;
    int trims;

    function int find_key(logic [31:0] key);
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    // Lowest cost, ties go to the lowest slot (or highest cost when hi is set).
    function int find_extreme(bit hi);
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i] && (best < 0 ||
            (hi ? slot_val[i] > slot_val[best] : slot_val[i] < slot_val[best])))
          best = i;
      return best;
    endfunction

    function void drop(int i);
      slot_used[i] = 0;
      if (used_count > 0) used_count--;
    endfunction

    function void note_request(logic [2:0] cmd, logic [31:0] key, logic [31:0] c,
                               logic [8:0] n);
      queue_result_t r;
      int i;
      int k;
      r.status = ST_OK;
      r.pop_coord = '0;
      r.pop_cost = '0;
      case (cmd)
        CMD_PUSH: begin
          i = find_key(key);
          if (i >= 0) begin
            slot_val[i] = c;
          end else begin
            i = -1;
            for (int j = 0; j < NSLOT && i < 0; j++)
              if (!slot_used[j]) i = j;
            if (i < 0) begin
              r.status = ST_FULL;
              fulls++;
            end else begin
              slot_used[i] = 1;
              slot_key[i] = key;
              slot_val[i] = c;
              used_count++;
            end
          end
        end
        CMD_POP: begin
          i = find_extreme(0);
          if (i < 0) begin
            r.status = ST_MISS;
          end else begin
            r.pop_coord = slot_key[i];
            r.pop_cost = slot_val[i];
            drop(i);
            pops++;
          end
        end
        CMD_REMOVE: begin
          i = find_key(key);
          if (i >= 0 && slot_val[i] == c) drop(i);
          else r.status = ST_MISS;
        end
        CMD_CONTAINS: r.status = (find_key(key) >= 0) ? ST_OK : ST_MISS;
        CMD_TRIM: begin
          k = int'(n);
          trims++;
          while (k > 0) begin
            i = find_extreme(1);
            if (i < 0) break;
            drop(i);
            k--;
          end
        end
        default: r.status = ST_MISS;
      endcase
      i = find_extreme(0);
      r.min_coord = (i >= 0) ? slot_key[i] : '0;
      r.min_cost = (i >= 0) ? slot_val[i] : '0;
      r.empty = (i < 0);
      r.len = used_count[LW-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status); errors++;
      end
      if (got.pop_coord !== e.pop_coord) begin
        $error("out_coord: expected %h, actual %h", e.pop_coord, got.pop_coord); errors++;
      end
      if (got.pop_cost !== e.pop_cost) begin
        $error("out_cost: expected %h, actual %h", e.pop_cost, got.pop_cost); errors++;
      end
      if (got.min_coord !== e.min_coord) begin
        $error("min_coord: expected %h, actual %h", e.min_coord, got.min_coord); errors++;
      end
      if (got.min_cost !== e.min_cost) begin
        $error("min_cost: expected %h, actual %h", e.min_cost, got.min_cost); errors++;
      end
      if (got.empty !== e.empty) begin
        $error("is_empty: expected %0d, actual %0d", e.empty, got.empty); errors++;
      end
      if (got.len !== e.len) begin
        $error("length: expected %0d, actual %0d", e.len, got.len); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_cmd;
  logic [31:0] in_coord;
  logic [31:0] in_cost;
  logic [8:0] in_count;
  logic out_valid;
  logic [1:0] out_status;
  logic [31:0] out_coord;
  logic [31:0] out_cost;
  logic [31:0] out_min_coord;
  logic [31:0] out_min_cost;
  logic out_is_empty;
  logic [LW-1:0] out_length;

  mpq_scoreboard sb;
  logic [31:0] key_pool[POOL];
  int sent;

  indexed_min_priority_queue_top #(.ENTRIES(NSLOT)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_coord(in_coord), .in_cost(in_cost), .in_count(in_count),
    .out_valid(out_valid), .out_status(out_status), .out_coord(out_coord),
    .out_cost(out_cost), .out_min_coord(out_min_coord), .out_min_cost(out_min_cost),
    .out_is_empty(out_is_empty), .out_length(out_length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("** indexed_min_priority_queue_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.pop_coord = out_coord;
      got.pop_cost = out_cost;
      got.min_coord = out_min_coord;
      got.min_cost = out_min_cost;
      got.empty = out_is_empty;
      got.len = out_length;
      sb.check_result(got);
    end
  end

  // Holds start high until the request is taken; start stays high afterwards.
  task automatic issue(logic [2:0] cmd, logic [31:0] key, logic [31:0] c, logic [8:0] n);
    start <= 1'b1;
    in_cmd <= cmd;
    in_coord <= key;
    in_cost <= c;
    in_count <= n;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, key, c, n);
    sent++;
  endtask

  task automatic idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    idle(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 3) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request(int mode);
    logic [31:0] key;
    logic [31:0] c;
    int p;
    int i;
    key = ($urandom_range(0, 19) == 0) ? $urandom : key_pool[$urandom_range(0, POOL - 1)];
    c = pick_cost();
    p = $urandom_range(0, 99);
    // Fill mode leans on push so the table reaches full; drain mode empties it.
    if (mode == 0) p = (p < 85) ? 0 : p;
    if (mode == 2) p = (p < 10) ? 0 : 10 + p % 90;
    if (p < 30 || (mode == 0 && p == 0)) begin
      issue(CMD_PUSH, key, c, 9'($urandom));
    end else if (p < 50) begin
      issue(CMD_POP, $urandom, $urandom, 9'($urandom));
    end else if (p < 68) begin
      i = sb.find_key(key);
      if (i >= 0 && $urandom_range(0, 3) != 0) c = sb.slot_val[i];
      issue(CMD_REMOVE, key, c, 9'($urandom));
    end else if (p < 82) begin
      issue(CMD_CONTAINS, key, $urandom, 9'($urandom));
    end else if (p < 94) begin
      issue(CMD_TRIM, $urandom, $urandom,
            9'(($urandom_range(0, 29) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 4)));
    end else begin
      issue(3'(int'(CMD_TRIM) + 1 + int'($urandom_range(0, 2))), $urandom, $urandom,
            9'($urandom));
    end
  endtask

  initial begin
    int mode;
    int burst;
    sb = new();
    sent = 0;
    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_PUSH;
    in_coord = '0;
    in_cost = '0;
    in_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, extremes, update in place, ties, misses, trims.
    issue(CMD_POP, 32'h0, 32'h0, 9'd0);
    issue(CMD_TRIM, 32'h0, 32'h0, 9'd3);
    issue(CMD_PUSH, 32'h0000_0000, 32'h0000_0000, 9'd0);
    issue(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
    issue(CMD_PUSH, 32'h0000_0000, 32'h0005_0000, 9'd0);
    issue(CMD_PUSH, 32'h8000_7FFF, 32'h0005_0000, 9'd0);
    issue(CMD_PUSH, 32'h7FFF_8000, 32'h0005_0000, 9'd0);
    issue(CMD_CONTAINS, 32'h8000_7FFF, 32'h0, 9'd0);
    issue(CMD_CONTAINS, 32'h1234_5678, 32'h0, 9'd0);
    issue(CMD_REMOVE, 32'h8000_7FFF, 32'h0005_0001, 9'd0);
    issue(CMD_REMOVE, 32'h1234_5678, 32'h0005_0000, 9'd0);
    issue(CMD_REMOVE, 32'h8000_7FFF, 32'h0005_0000, 9'd0);
    issue(CMD_POP, 32'h0, 32'h0, 9'd0);
    issue(CMD_PUSH, 32'h0001_0001, 32'hFFFF_FFFF, 9'd0);
    issue(CMD_TRIM, 32'h0, 32'h0, 9'd1);
    issue(CMD_TRIM, 32'h0, 32'h0, 9'd0);
    issue(3'd5, 32'h0, 32'h0, 9'd0);
    issue(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
    issue(3'd7, 32'h0, 32'h0, 9'd0);
    issue(CMD_TRIM, 32'h0, 32'h0, 9'd256);
    settle();

    mode = 0;
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 59) == 0) mode = $urandom_range(0, 2);
      if (sb.used_count == NSLOT && $urandom_range(0, 3) == 0) mode = 1;
      burst = $urandom_range(1, 20);
      repeat (burst) random_request(mode);
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 30));
      if (sent >= NUM_ITEMS / 2 && sent < NUM_ITEMS / 2 + 21) settle();
    end

    idle(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES / 100) @(posedge clk);
    $display("Sent %0d requests, %0d results checked: %0d pops, %0d trims, %0d table-full pushes.",
             sent, sb.results_seen, sb.pops, sb.trims, sb.fulls);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** indexed_min_priority_queue_top: PASSED **");
    end else begin
      $display("** indexed_min_priority_queue_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/impq_pkg.sv
rtl/core/impq_ctrl.sv
rtl/core/impq_dp.sv
rtl/core/indexed_min_priority_queue_top.sv
rtl/core/impq_checker.sv
test/testbench.sv
